[hdl/rsa_me_pkg.sv]
// Shared constants and types for the RSA modular exponentiation block.
`timescale 1ns / 1ps

package rsa_me_pkg;

    // Width of the modulus datapath; the modulus register is cut to its low bits.
    localparam int MOD_WIDTH  = 32;
    localparam int VALUE_W    = 32;
    localparam int DATA_W     = (MOD_WIDTH > VALUE_W) ? VALUE_W : MOD_WIDTH;
    localparam int EXP_W      = 32;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int BIT_IDX_W  = $clog2(EXP_W);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_EXPONENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MODULUS  = 1'b1;

    localparam logic [EXP_W-1:0]   KEY_EXPONENT_RESET = EXP_W'(1);
    localparam logic [VALUE_W-1:0] KEY_MODULUS_RESET  = VALUE_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EXP_MUL,
        ST_EXP_SQR,
        ST_FINISH
    } state_t;

endpackage

[hdl/rsa_modular_exponentiation.sv]
// Top level: modular exponentiation by square-and-multiply on a bit-serial modular multiplier.
// An accepted value is first reduced, then each of the 32 exponent bits takes a squaring and, for a
// set bit, a multiply before it; a modulus below 2 skips straight to the result, which is then zero.
// One item is in work at a time; the next is taken in the cycle after the result is loaded, and
// loading waits while an earlier result is still held on m_tvalid without m_tready.
// Synchronous active-low reset restores exponent 1, modulus 2 and an empty output.
`timescale 1ns / 1ps

module rsa_modular_exponentiation (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rsa_me_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsa_me_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rsa_me_pkg::VALUE_W-1:0]      s_tdata,   // [31:0] value_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rsa_me_pkg::VALUE_W-1:0]      m_tdata    // [31:0] value_out
);
    import rsa_me_pkg::*;

    state_t state_reg, state_next;

    logic [EXP_W-1:0]     key_exponent_reg;
    logic [VALUE_W-1:0]   key_modulus_reg;

    logic [VALUE_W-1:0]   a_reg, a_next;
    logic [DATA_W-1:0]    b_reg, b_next;
    logic [DATA_W-1:0]    r_reg, r_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DATA_W-1:0]    acc_reg, acc_next;
    logic [DATA_W-1:0]    sq_reg, sq_next;
    logic [BIT_IDX_W-1:0] bit_idx_reg, bit_idx_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0]   m_tdata_reg, m_tdata_next;

    logic [DATA_W-1:0]    modulus;
    logic                 modulus_small;
    logic                 in_accept;
    logic                 out_load;
    logic [DATA_W-1:0]    addend;
    logic [DATA_W+1:0]    sum;
    logic [DATA_W+2:0]    diff_one;
    logic [DATA_W+2:0]    diff_two;
    logic [DATA_W-1:0]    r_step;
    logic                 mul_last;
    logic [BIT_IDX_W-1:0] bit_idx_inc;
    logic                 exp_last;
    logic                 next_exp_bit;
    logic                 mul_start;
    logic [DATA_W-1:0]    mul_a_op;

    assign modulus       = key_modulus_reg[DATA_W-1:0];
    assign modulus_small = (modulus[DATA_W-1:1] == '0);
    assign in_accept     = s_tvalid && s_tready;
    assign out_load      = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    // One step of the interleaved multiplier: r = (2r + bit*b) mod m. The sum stays below 3m, so
    // subtracting 2m if that leaves a non-negative value, else m if it does, else nothing, finishes it.
    assign addend   = a_reg[VALUE_W-1] ? b_reg : '0;
    assign sum      = {1'b0, r_reg, 1'b0} + {2'b00, addend};
    assign diff_one = {1'b0, sum} - {3'b000, modulus};
    assign diff_two = {1'b0, sum} - {2'b00, modulus, 1'b0};

    always_comb begin
        if (!diff_two[DATA_W+2]) begin
            r_step = diff_two[DATA_W-1:0];
        end else if (!diff_one[DATA_W+2]) begin
            r_step = diff_one[DATA_W-1:0];
        end else begin
            r_step = sum[DATA_W-1:0];
        end
    end

    // The input reduction runs over all input bits, the exponent products over the datapath width.
    assign mul_last = (state_reg == ST_REDUCE) ? (cnt_reg == CNT_W'(VALUE_W - 1))
                                               : (cnt_reg == CNT_W'(DATA_W - 1));

    assign bit_idx_inc  = bit_idx_reg + 1'b1;
    assign exp_last     = (bit_idx_reg == BIT_IDX_W'(EXP_W - 1));
    assign next_exp_bit = key_exponent_reg[bit_idx_inc];

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = modulus_small ? ST_FINISH : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (mul_last) begin
                    state_next = key_exponent_reg[0] ? ST_EXP_MUL : ST_EXP_SQR;
                end
            end
            ST_EXP_MUL: begin
                if (mul_last) begin
                    state_next = ST_EXP_SQR;
                end
            end
            ST_EXP_SQR: begin
                if (mul_last) begin
                    if (exp_last) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = next_exp_bit ? ST_EXP_MUL : ST_EXP_SQR;
                    end
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata  = m_tdata_reg;
    end

    // Datapath next values.
    always_comb begin
        acc_next      = acc_reg;
        sq_next       = sq_reg;
        bit_idx_next  = bit_idx_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        r_next        = r_reg;
        cnt_next      = cnt_reg;
        mul_start     = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    // Reduce the input by multiplying it by one.
                    acc_next = '0;
                    a_next   = s_tdata;
                    b_next   = DATA_W'(1);
                    r_next   = '0;
                    cnt_next = '0;
                end
            end
            ST_REDUCE, ST_EXP_MUL, ST_EXP_SQR: begin
                a_next   = {a_reg[VALUE_W-2:0], 1'b0};
                r_next   = r_step;
                cnt_next = cnt_reg + 1'b1;
                if (mul_last) begin
                    case (state_reg)
                        ST_REDUCE: begin
                            sq_next      = r_step;
                            acc_next     = DATA_W'(1);
                            bit_idx_next = '0;
                            mul_start    = 1'b1;
                        end
                        ST_EXP_MUL: begin
                            acc_next  = r_step;
                            mul_start = 1'b1;
                        end
                        default: begin
                            sq_next      = r_step;
                            bit_idx_next = bit_idx_inc;
                            mul_start    = !exp_last;
                        end
                    endcase
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = VALUE_W'(acc_reg);
                end
            end
            default: ;
        endcase

        // The multiplier operand of the next product sits at the top of the shift register; b takes the square.
        mul_a_op = (state_next == ST_EXP_MUL) ? acc_next : sq_next;
        if (mul_start) begin
            a_next   = VALUE_W'(mul_a_op) << (VALUE_W - DATA_W);
            b_next   = sq_next;
            r_next   = '0;
            cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            key_exponent_reg <= KEY_EXPONENT_RESET;
            key_modulus_reg  <= KEY_MODULUS_RESET;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_KEY_EXPONENT: key_exponent_reg <= EXP_W'(cfg_data);
                    CFG_KEY_MODULUS:  key_modulus_reg  <= VALUE_W'(cfg_data);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        r_reg       <= r_next;
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        sq_reg      <= sq_next;
        bit_idx_reg <= bit_idx_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule
